>>> hdl/sfm_pkg.sv
// shared constants, types and codes of the substring first-match block
package sfm_pkg;

   localparam int PATTERN_MAX   = 32;
   localparam int POSITION_BITS = 16;
   localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int CHAR_BITS     = 8;
   localparam int OUT_POS_BITS  = 16;

   typedef logic [CHAR_BITS-1:0]     char_type;
   typedef logic [LEN_BITS-1:0]      len_type;
   typedef logic [POSITION_BITS-1:0] count_type;
   typedef logic [OUT_POS_BITS-1:0]  out_pos_type;
   typedef logic [1:0]               op_code_type;

   localparam count_type COUNT_MAX = {POSITION_BITS{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2
   } op_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic     shift;
      logic     clear;
      char_type character;
   } cell_ctrl_type;

   typedef struct packed {
      logic        found;
      out_pos_type position;
      logic        pattern_truncated;
   } result_type;

endpackage

>>> hdl/sfm_req_if.sv
// input channel: operation, character and last-beat flag
interface sfm_req_if;
   logic                   valid;
   logic                   ready;
   sfm_pkg::op_code_type   operation;
   sfm_pkg::char_type      character;
   logic                   is_last;

   modport source (output valid, output operation, output character, output is_last,
                   input ready);
   modport sink   (input valid, input operation, input character, input is_last,
                   output ready);
endinterface

>>> hdl/sfm_rsp_if.sv
// result channel: found flag, match position and truncation flag
interface sfm_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   found;
   sfm_pkg::out_pos_type   position;
   logic                   pattern_truncated;

   modport source (output valid, output found, output position, output pattern_truncated,
                   input ready);
   modport sink   (input valid, input found, input position, input pattern_truncated,
                   output ready);
endinterface

>>> hdl/sfm_cell.sv
// one compare cell: a pattern byte and the partial-match flag ending at it
module sfm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sfm_pkg::cell_ctrl_type ctrl,
   input  logic                   load,
   input  logic                   tail,
   input  logic                   chain_in,
   output logic                   chain_out,
   output logic                   hit
);

   sfm_pkg::char_type pattern_ff;
   logic              match_ff;
   logic              match_in;
   logic              step_match;

   // previous cell matched one beat ago and this byte matches too
   assign step_match = chain_in && (ctrl.character == pattern_ff);

   always_comb begin
      priority if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = step_match;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pattern_ff <= ctrl.character;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign chain_out = match_ff;
   assign hit       = ctrl.shift && tail && step_match;

endmodule

>>> hdl/sfm_result_queue.sv
// two-entry result queue between the search logic and the result channel
module sfm_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfm_pkg::result_type push_data,
   output logic                space,
   sfm_rsp_if.source           rsp_chan
);

   sfm_pkg::result_type head_ff, head_in;
   sfm_pkg::result_type tail_ff, tail_in;
   logic                head_valid_ff, head_valid_in;
   logic                tail_valid_ff, tail_valid_in;
   logic                pop;

   assign pop = head_valid_ff && rsp_chan.ready;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
      if (push) begin
         if (!head_valid_in) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = push_data;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   assign space                      = !tail_valid_ff;
   assign rsp_chan.valid             = head_valid_ff;
   assign rsp_chan.found             = head_ff.found;
   assign rsp_chan.position          = head_ff.position;
   assign rsp_chan.pattern_truncated = head_ff.pattern_truncated;

endmodule

>>> hdl/substring_first_match.sv
// top level: first occurrence of a stored pattern in a streamed text
// throughput: one beat per cycle on the input, pattern load and text alike, while the output queue has room
// the result beat is registered in the output queue when the last text beat is taken
// the compare is a chain of PATTERN_MAX cells, one partial-match flag per pattern byte
// input stalls only while two results wait in the output queue
// reset (synchronous) clears length, flags, counters and match flags; pattern bytes keep
module substring_first_match (
   input  logic      clock,
   input  logic      reset,
   sfm_req_if.sink   req_chan,
   sfm_rsp_if.source rsp_chan
);

   localparam int MAX = sfm_pkg::PATTERN_MAX;

   // search state
   sfm_pkg::len_type   len_ff, len_in;
   logic               overflow_ff, overflow_in;
   sfm_pkg::count_type count_ff, count_in;
   logic               seen_ff, seen_in;
   sfm_pkg::count_type pos_ff, pos_in;

   logic                   accept;
   logic                   space;
   logic                   is_clear, is_append, is_text;
   logic                   text_clear;
   logic                   hit_any;
   logic                   push;
   sfm_pkg::count_type     count_next;
   sfm_pkg::count_type     hit_pos;
   sfm_pkg::result_type    result;
   sfm_pkg::cell_ctrl_type ctrl;

   logic [MAX-1:0] load;
   logic [MAX-1:0] tail;
   logic [MAX-1:0] hit;
   logic [MAX:0]   chain;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = space;

   // decode the operation of an accepted beat; unused code does nothing
   always_comb begin
      is_clear  = 1'b0;
      is_append = 1'b0;
      is_text   = 1'b0;
      unique case (req_chan.operation)
         sfm_pkg::OP_CLEAR:  is_clear  = accept;
         sfm_pkg::OP_APPEND: is_append = accept;
         sfm_pkg::OP_TEXT:   is_text   = accept;
         default: ;
      endcase
   end

   // any pattern edit drops the text in progress, as does the end of a text
   assign text_clear = is_clear || is_append || (is_text && req_chan.is_last);

   assign ctrl.shift     = is_text;
   assign ctrl.clear     = text_clear;
   assign ctrl.character = req_chan.character;

   // cell 0 always sees a matched empty prefix
   assign chain[0] = 1'b1;

   for (genvar i = 0; i < MAX; i++) begin : g_cell
      // next free slot takes the appended byte; the cell at length-1 ends the pattern
      assign load[i] = is_append && (len_ff == sfm_pkg::len_type'(i));
      assign tail[i] = (len_ff == sfm_pkg::len_type'(i + 1));

      sfm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load      (load[i]),
         .tail      (tail[i]),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .hit       (hit[i])
      );
   end

   // empty pattern has no tail cell, so it never hits
   assign hit_any = |hit;

   // saturating text counter
   assign count_next = (count_ff != sfm_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign hit_pos    = count_next - sfm_pkg::count_type'(len_ff);

   always_comb begin
      len_in      = len_ff;
      overflow_in = overflow_ff;
      count_in    = count_ff;
      seen_in     = seen_ff;
      pos_in      = pos_ff;
      if (is_clear) begin
         len_in      = '0;
         overflow_in = 1'b0;
      end
      if (is_append) begin
         if (len_ff < sfm_pkg::len_type'(MAX)) begin
            len_in = len_ff + 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (is_text) begin
         count_in = count_next;
         if (!seen_ff && hit_any) begin
            seen_in = 1'b1;
            pos_in  = hit_pos;
         end
      end
      if (text_clear) begin
         count_in = '0;
         seen_in  = 1'b0;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         overflow_ff <= 1'b0;
         count_ff    <= '0;
         seen_ff     <= 1'b0;
         pos_ff      <= '0;
      end else begin
         len_ff      <= len_in;
         overflow_ff <= overflow_in;
         count_ff    <= count_in;
         seen_ff     <= seen_in;
         pos_ff      <= pos_in;
      end
   end

   // result of the last text beat, including a hit on that very beat
   assign push                     = is_text && req_chan.is_last;
   assign result.found             = seen_ff || hit_any;
   assign result.pattern_truncated = overflow_ff;

   always_comb begin
      priority if (seen_ff) begin
         result.position = sfm_pkg::out_pos_type'(pos_ff);
      end else if (hit_any) begin
         result.position = sfm_pkg::out_pos_type'(hit_pos);
      end else begin
         result.position = '0;
      end
   end

   sfm_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> hdl/sfm_checker.sv
// port-level checks of the substring first-match block and their bind
module sfm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input sfm_pkg::op_code_type req_operation,
   input logic                 req_is_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input sfm_pkg::out_pos_type rsp_position
);

   logic last_beat;

   assign last_beat = req_valid && req_ready && req_is_last &&
                      (req_operation == sfm_pkg::OP_TEXT);

   // a result beat only shows up after a last text beat
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_beat))
      else $error("result appeared without a last text beat");

   // no match means position zero
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0))
      else $error("position nonzero without a match");

   // input stalls only while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // queue fills only through a last text beat while a result is held
   a_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(last_beat && rsp_valid && !rsp_ready))
      else $error("input stalled without a result being queued");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .req_is_last   (req_chan.is_last),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.found),
   .rsp_position  (rsp_chan.position)
);

>>> verif/testbench.sv
// self-checking bench for the substring first-match block: pattern loads, text beats, results
module testbench;
   import sfm_pkg::*;

   // the one operation code the block has to ignore
   localparam op_code_type OP_UNUSED = 2'd3;

   localparam int HOLDOFF_CYCLES = 300;   // long receiver stall that backs the block up
   localparam int STALL_LIMIT    = 2000;  // cycles with no beat on either side before giving up
   localparam int MAX_PRINTED    = 40;

   // tracks the block's state beat by beat and holds the results it still owes
   class match_board;
      char_type    pattern[PATTERN_MAX];
      len_type     pattern_len;
      logic        overflow;
      char_type    recent[PATTERN_MAX];  // recent[k] is the text byte seen k beats ago
      count_type   text_count;
      logic        match_seen;
      count_type   match_pos;
      result_type  owed_results[$];
      int          error_count;

      function new();
         foreach (pattern[i]) pattern[i] = '0;
         pattern_len = '0;
         overflow    = 1'b0;
         error_count = 0;
         drop_text();
      endfunction

      function void drop_text();
         foreach (recent[i]) recent[i] = '0;
         text_count = '0;
         match_seen = 1'b0;
         match_pos  = '0;
      endfunction

      // newest pattern_len text bytes against the whole pattern, oldest first
      function logic window_hits();
         if (pattern_len == 0) return 1'b0;
         if (text_count < count_type'(pattern_len)) return 1'b0;
         for (int i = 0; i < pattern_len; i++)
            if (pattern[i] != recent[pattern_len - 1 - i]) return 1'b0;
         return 1'b1;
      endfunction

      task report(input string msg);
         if (error_count < MAX_PRINTED) $display("mismatch: %s", msg);
         error_count++;
      endtask

      task note_beat(input op_code_type op, input char_type ch, input logic last);
         result_type res;
         case (op)
            OP_CLEAR: begin
               pattern_len = '0;
               overflow    = 1'b0;
               drop_text();
            end
            OP_APPEND: begin
               if (pattern_len < PATTERN_MAX) begin
                  pattern[pattern_len] = ch;
                  pattern_len++;
               end else begin
                  overflow = 1'b1;
               end
               drop_text();
            end
            OP_TEXT: begin
               for (int k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
               recent[0] = ch;
               if (text_count != COUNT_MAX) text_count++;
               if (!match_seen && window_hits()) begin
                  match_seen = 1'b1;
                  match_pos  = text_count - count_type'(pattern_len);
               end
               if (last) begin
                  res.found             = match_seen;
                  res.position          = match_seen ? out_pos_type'(match_pos) : '0;
                  res.pattern_truncated = overflow;
                  owed_results.push_back(res);
                  drop_text();
               end
            end
            default: ;
         endcase
      endtask

      task check_result(input logic found, input out_pos_type position, input logic truncated);
         result_type want;
         if (owed_results.size() == 0) begin
            report("result beat arrived with none owed");
            return;
         end
         want = owed_results.pop_front();
         if (found !== want.found)
            report($sformatf("found %b, wanted %b", found, want.found));
         if (position !== want.position)
            report($sformatf("position %0d, wanted %0d", position, want.position));
         if (truncated !== want.pattern_truncated)
            report($sformatf("pattern_truncated %b, wanted %b", truncated,
                             want.pattern_truncated));
      endtask

      task finish_check();
         while (owed_results.size() != 0) begin
            report("result never arrived");
            void'(owed_results.pop_front());
         end
      endtask
   endclass

   logic clock;
   logic reset;

   sfm_req_if req_bus ();
   sfm_rsp_if rsp_bus ();

   substring_first_match dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   match_board  search_board;
   int unsigned beats_sent;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   logic        holdoff_request;
   char_type    loaded[$];  // pattern bytes the block holds, as far as the stimulus knows

   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // every input known from time zero
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_CLEAR;
      req_bus.character <= '0;
      req_bus.is_last   <= 1'b0;
   end

   // both channels are watched at the edge; values read here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            search_board.note_beat(req_bus.operation, req_bus.character, req_bus.is_last);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            search_board.check_result(rsp_bus.found, rsp_bus.position,
                                      rsp_bus.pattern_truncated);
      end
   end

   // receiver: random ready, or a long hold-off counted right here
   initial begin : receiver
      int hold_count;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            rsp_bus.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLDOFF_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            holdoff_request = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // a stretch with no beat on either channel means the block is hung
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // one input beat, with a random gap in front; returns at the edge that takes it
   task automatic send_beat(input op_code_type op, input char_type ch, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.character <= ch;
      req_bus.is_last   <= last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      beats_sent++;
   endtask

   // is_last on pattern beats is don't-care, so it is random there
   task automatic clear_pattern();
      send_beat(OP_CLEAR, char_type'($urandom), 1'($urandom_range(1)));
      loaded.delete();
   endtask

   task automatic append_char(input char_type ch);
      send_beat(OP_APPEND, ch, 1'($urandom_range(1)));
      if (loaded.size() < PATTERN_MAX) loaded.push_back(ch);
   endtask

   // mostly a three-letter alphabet so matches and near misses are common
   function automatic char_type pick_char();
      if ($urandom_range(3) == 0) return char_type'($urandom);
      return char_type'(8'h61 + $urandom_range(2));
   endfunction

   task automatic send_text(input char_type txt[$]);
      foreach (txt[i]) send_beat(OP_TEXT, txt[i], i == txt.size() - 1);
   endtask

   task automatic load_pattern(input int count);
      clear_pattern();
      repeat (count) append_char(pick_char());
   endtask

   // random text, often with a copy of the loaded pattern planted somewhere in it
   task automatic random_text();
      char_type txt[$];
      int       span;
      int       start;
      span = $urandom_range(1, 12);
      if (loaded.size() > 0 && $urandom_range(1)) span += loaded.size();
      repeat (span) txt.push_back(pick_char());
      if (loaded.size() > 0 && span >= loaded.size() && $urandom_range(2) != 0) begin
         start = $urandom_range(span - loaded.size());
         foreach (loaded[i]) txt[start + i] = loaded[i];
      end
      send_text(txt);
   endtask

   // stop offering and let every owed result come out
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (search_board.owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned stop_at;
      int          pick;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_beat(OP_UNUSED, char_type'($urandom), 1'($urandom_range(1)));
         end else if (pick < 8) begin
            // text cut short by a clear or an append, no result for it
            send_beat(OP_TEXT, pick_char(), 1'b0);
            if ($urandom_range(1)) clear_pattern();
            else append_char(pick_char());
         end else if (pick < 11) begin
            // empty pattern
            load_pattern(0);
            random_text();
         end else if (pick < 30) begin
            // now and then a pattern near or past capacity
            load_pattern(($urandom_range(7) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 4));
         end else if (pick < 35) begin
            append_char(pick_char());
         end else begin
            random_text();
         end
      end
   endtask

   initial begin : stimulus
      search_board      = new();
      beats_sent        = 0;
      holdoff_request   = 1'b0;
      sender_idle_pct   = 22;
      receiver_idle_pct = 86;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty pattern after reset never matches
      send_beat(OP_TEXT, 8'h00, 1'b1);
      // unused operation, even with is_last, does nothing
      send_beat(OP_UNUSED, 8'hFF, 1'b1);
      // all-zero pattern vs the zero-filled window: too few bytes yet, then a hit at 0
      send_beat(OP_APPEND, 8'h00, 1'b1);
      send_beat(OP_APPEND, 8'h00, 1'b0);
      loaded = '{8'h00, 8'h00};
      send_beat(OP_TEXT, 8'h00, 1'b1);
      send_beat(OP_TEXT, 8'h00, 1'b0);
      send_beat(OP_TEXT, 8'h00, 1'b1);
      // top-bit bytes, two occurrences: the first one is kept
      clear_pattern();
      append_char(8'hFF);
      append_char(8'h80);
      send_beat(OP_TEXT, 8'h01, 1'b0);
      send_beat(OP_TEXT, 8'hFF, 1'b0);
      send_beat(OP_TEXT, 8'h80, 1'b0);
      send_beat(OP_TEXT, 8'hFF, 1'b0);
      send_beat(OP_TEXT, 8'h80, 1'b1);
      // append in the middle of a text restarts the text
      send_beat(OP_TEXT, 8'hFF, 1'b0);
      append_char(8'h80);
      send_beat(OP_TEXT, 8'h80, 1'b1);
      send_beat(OP_TEXT, 8'hFF, 1'b0);
      send_beat(OP_TEXT, 8'h80, 1'b0);
      send_beat(OP_TEXT, 8'h80, 1'b1);
      // clear in the middle of a text drops it without a result
      send_beat(OP_TEXT, 8'h7F, 1'b0);
      clear_pattern();
      send_beat(OP_TEXT, 8'h7F, 1'b1);
      wait_for_results();

      random_phase(240);
      wait_for_results();

      sender_idle_pct   = 86;
      receiver_idle_pct = 22;
      random_phase(240);
      wait_for_results();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      random_phase(220);
      wait_for_results();

      // receiver stalls while one-beat texts keep coming: output queue fills, input backs up
      holdoff_request = 1'b1;
      repeat (12) send_beat(OP_TEXT, pick_char(), 1'b1);
      wait_for_results();

      // bytes past capacity are dropped and flagged; the stored 32 still match
      clear_pattern();
      repeat (34) append_char(char_type'($urandom));
      send_text(loaded);
      wait_for_results();

      // let anything stray show up before the final check
      repeat (10) @(posedge clock);
      search_board.finish_check();
      if (search_board.error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/sfm_pkg.sv
hdl/sfm_req_if.sv
hdl/sfm_rsp_if.sv
hdl/sfm_cell.sv
hdl/sfm_result_queue.sv
hdl/substring_first_match.sv
hdl/sfm_checker.sv
verif/testbench.sv
